### rtl/utf8_to_ascii_json_escaper_macros.svh
// Assertion helpers shared by the RTL files that check themselves.
// Both expect clk and an active-low rst_n in the enclosing scope.
`ifndef UTF8_TO_ASCII_JSON_ESCAPER_MACROS_SVH
`define UTF8_TO_ASCII_JSON_ESCAPER_MACROS_SVH

// Same-cycle implication
`define U8ESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define U8ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/u8esc_pkg.sv
package u8esc_pkg;

  // What the main part of a job prints
  typedef enum logic [2:0] {
    KIND_NONE,   // nothing (waiting or malformed sequence)
    KIND_CHAR1,  // one plain character
    KIND_CHAR2,  // backslash and one character
    KIND_U16,    // one \uXXXX
    KIND_PAIR    // surrogate pair, two \uXXXX
  } kind_t;

  // One queued job: replacements, main part, replacements after end flag
  typedef struct packed {
    logic [2:0]  pre;
    kind_t       kind;
    logic [6:0]  main_char;
    logic [15:0] code_hi;
    logic [15:0] code_lo;
    logic [1:0]  post;
  } job_t;

  // Back-end sequencer segment
  typedef enum logic [1:0] {
    SEG_PRE,
    SEG_MAIN,
    SEG_POST
  } seg_t;

  localparam logic [6:0]  CHAR_BSLASH = 7'h5c;
  localparam logic [6:0]  CHAR_QUOTE  = 7'h22;
  localparam logic [6:0]  CHAR_U      = 7'h75;
  localparam logic [6:0]  CHAR_B      = 7'h62;
  localparam logic [6:0]  CHAR_T      = 7'h74;
  localparam logic [6:0]  CHAR_N      = 7'h6e;
  localparam logic [6:0]  CHAR_F      = 7'h66;
  localparam logic [6:0]  CHAR_R      = 7'h72;
  localparam logic [15:0] REPL_CODE   = 16'hfffd;

  localparam logic [6:0] HEX_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  // Character at position pos (0..5) of \uXXXX for a 16-bit code
  function automatic logic [6:0] u16_char(input logic [15:0] code, input logic [2:0] pos);
    logic [6:0] c;
    case (pos)
      3'd0:    c = CHAR_BSLASH;
      3'd1:    c = CHAR_U;
      3'd2:    c = HEX_CHARS[code[15:12]];
      3'd3:    c = HEX_CHARS[code[11:8]];
      3'd4:    c = HEX_CHARS[code[7:4]];
      3'd5:    c = HEX_CHARS[code[3:0]];
      default: c = CHAR_BSLASH;
    endcase
    return c;
  endfunction

endpackage

### rtl/u8esc_front.sv
module u8esc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  input  logic              q_full,
  output logic              push,
  output u8esc_pkg::job_t   push_job
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] pend0_r, pend0_nxt;
  logic [7:0] pend1_r, pend1_nxt;
  logic [7:0] pend2_r, pend2_nxt;

  logic        accept;
  logic        is_cont;
  logic        fresh;
  logic [2:0]  need;
  logic [10:0] code2;
  logic [15:0] code3;
  logic [20:0] code4;
  logic [19:0] off4;
  logic        seq_ok;
  u8esc_pkg::job_t job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte[7:6] == 2'b10);

  // Sequence length from the lead byte
  always_comb begin
    if (pend0_r[7:5] == 3'b110) begin
      need = 3'd2;
    end else if (pend0_r[7:4] == 4'b1110) begin
      need = 3'd3;
    end else begin
      need = 3'd4;
    end
  end

  // Decoded code points and range checks
  assign code2 = {pend0_r[4:0], in_byte[5:0]};
  assign code3 = {pend0_r[3:0], pend1_r[5:0], in_byte[5:0]};
  assign code4 = {pend0_r[2:0], pend1_r[5:0], pend2_r[5:0], in_byte[5:0]};
  assign off4  = 20'(code4 - 21'h010000);

  always_comb begin
    unique case (need)
      3'd2:    seq_ok = (code2 >= 11'h080);
      3'd3:    seq_ok = (code3 >= 16'h0800) && (code3[15:11] != 5'b11011);
      default: seq_ok = (code4 >= 21'h010000) && (code4 <= 21'h10ffff);
    endcase
  end

  // Classify the byte into a job and the next pending state
  always_comb begin
    job       = '0;
    cnt_nxt   = cnt_r;
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    pend2_nxt = pend2_r;
    fresh     = 1'b0;

    if (cnt_r != 2'd0) begin
      if (is_cont) begin
        if (({1'b0, cnt_r} + 3'd1) >= need) begin
          cnt_nxt = 2'd0;
          if (!seq_ok) begin
            job.pre = need;
          end else if (need == 3'd4) begin
            job.kind    = u8esc_pkg::KIND_PAIR;
            job.code_hi = {6'b110110, off4[19:10]};
            job.code_lo = {6'b110111, off4[9:0]};
          end else begin
            job.kind    = u8esc_pkg::KIND_U16;
            job.code_hi = (need == 3'd2) ? {5'b0, code2} : code3;
          end
        end else begin
          if (cnt_r == 2'd1) begin
            pend1_nxt = in_byte;
          end else begin
            pend2_nxt = in_byte;
          end
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        // broken sequence: flush, then treat the byte on its own
        job.pre = {1'b0, cnt_r};
        cnt_nxt = 2'd0;
        fresh   = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (!in_byte[7]) begin
        if (in_byte[6:0] == u8esc_pkg::CHAR_QUOTE || in_byte[6:0] == u8esc_pkg::CHAR_BSLASH) begin
          job.kind      = u8esc_pkg::KIND_CHAR2;
          job.main_char = in_byte[6:0];
        end else if (in_byte >= 8'h20 && in_byte <= 8'h7e) begin
          job.kind      = u8esc_pkg::KIND_CHAR1;
          job.main_char = in_byte[6:0];
        end else begin
          job.kind = u8esc_pkg::KIND_CHAR2;
          unique case (in_byte[6:0])
            7'h08:   job.main_char = u8esc_pkg::CHAR_B;
            7'h09:   job.main_char = u8esc_pkg::CHAR_T;
            7'h0a:   job.main_char = u8esc_pkg::CHAR_N;
            7'h0c:   job.main_char = u8esc_pkg::CHAR_F;
            7'h0d:   job.main_char = u8esc_pkg::CHAR_R;
            default: begin
              job.kind    = u8esc_pkg::KIND_U16;
              job.code_hi = {8'h00, in_byte};
            end
          endcase
        end
      end else if (in_byte >= 8'hc0 && in_byte <= 8'hf7) begin
        pend0_nxt = in_byte;
        cnt_nxt   = 2'd1;
      end else begin
        job.kind    = u8esc_pkg::KIND_U16;
        job.code_hi = u8esc_pkg::REPL_CODE;
      end
    end

    // end flag flushes whatever is still pending
    if (end_of_text) begin
      job.post = cnt_nxt;
      cnt_nxt  = 2'd0;
    end
  end

  assign push_job = job;
  assign push     = accept &&
                    (job.pre != 3'd0 || job.kind != u8esc_pkg::KIND_NONE || job.post != 2'd0);

  // Pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Pending bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend0_r <= 8'h00;
      pend1_r <= 8'h00;
      pend2_r <= 8'h00;
    end else if (accept) begin
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
      pend2_r <= pend2_nxt;
    end
  end

endmodule

### rtl/u8esc_fifo.sv
`include "utf8_to_ascii_json_escaper_macros.svh"

module u8esc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8esc_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output u8esc_pkg::job_t  head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8esc_pkg::job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `U8ESC_ASSERT_NOW(a_no_overflow, full, !push, "job queue written while full")
  `U8ESC_ASSERT_NOW(a_no_underflow, !head_valid, !pop, "job queue read while empty")

endmodule

### rtl/u8esc_back.sv
`include "utf8_to_ascii_json_escaper_macros.svh"

module u8esc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  u8esc_pkg::job_t  head_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       out_char,
  output logic             last_of_run
);

  u8esc_pkg::seg_t seg_r, seg_nxt, seg_eff;
  logic [2:0] pos_r, pos_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       half_r, half_nxt;

  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_last_r;

  logic       load;
  logic [6:0] cur_char;
  logic       unit_end;
  logic       seg_end;
  logic       job_last;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && job_last;

  // Skip an empty replacement run at the start of a job
  always_comb begin
    if (seg_r == u8esc_pkg::SEG_PRE && head_job.pre == 3'd0) begin
      seg_eff = (head_job.kind != u8esc_pkg::KIND_NONE) ? u8esc_pkg::SEG_MAIN
                                                        : u8esc_pkg::SEG_POST;
    end else begin
      seg_eff = seg_r;
    end
  end

  // Output decode: current character and where it ends
  always_comb begin
    cur_char = u8esc_pkg::u16_char(u8esc_pkg::REPL_CODE, pos_r);
    unit_end = (pos_r == 3'd5);
    seg_end  = 1'b0;
    job_last = 1'b0;
    unique case (seg_eff)
      u8esc_pkg::SEG_PRE: begin
        seg_end  = unit_end && ({1'b0, cnt_r} == head_job.pre - 3'd1);
        job_last = seg_end && head_job.kind == u8esc_pkg::KIND_NONE &&
                   head_job.post == 2'd0;
      end
      u8esc_pkg::SEG_MAIN: begin
        case (head_job.kind)
          u8esc_pkg::KIND_CHAR1: begin
            cur_char = head_job.main_char;
            unit_end = 1'b1;
          end
          u8esc_pkg::KIND_CHAR2: begin
            cur_char = (pos_r == 3'd0) ? u8esc_pkg::CHAR_BSLASH : head_job.main_char;
            unit_end = (pos_r == 3'd1);
          end
          u8esc_pkg::KIND_U16: begin
            cur_char = u8esc_pkg::u16_char(head_job.code_hi, pos_r);
          end
          u8esc_pkg::KIND_PAIR: begin
            cur_char = u8esc_pkg::u16_char(half_r ? head_job.code_lo : head_job.code_hi,
                                           pos_r);
          end
          default: begin
            cur_char = u8esc_pkg::CHAR_BSLASH;
            unit_end = 1'b1;
          end
        endcase
        seg_end  = unit_end && (head_job.kind != u8esc_pkg::KIND_PAIR || half_r);
        job_last = seg_end && head_job.post == 2'd0;
      end
      u8esc_pkg::SEG_POST: begin
        seg_end  = unit_end && (cnt_r == head_job.post - 2'd1);
        job_last = seg_end;
      end
      default: begin
        seg_end  = 1'b1;
        job_last = 1'b1;
      end
    endcase
  end

  // Next state of the sequencer
  always_comb begin
    seg_nxt  = seg_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    half_nxt = half_r;
    if (load) begin
      seg_nxt = seg_eff;
      if (job_last) begin
        seg_nxt  = u8esc_pkg::SEG_PRE;
        pos_nxt  = 3'd0;
        cnt_nxt  = 2'd0;
        half_nxt = 1'b0;
      end else if (seg_end) begin
        pos_nxt  = 3'd0;
        cnt_nxt  = 2'd0;
        half_nxt = 1'b0;
        if (seg_eff == u8esc_pkg::SEG_PRE && head_job.kind != u8esc_pkg::KIND_NONE) begin
          seg_nxt = u8esc_pkg::SEG_MAIN;
        end else begin
          seg_nxt = u8esc_pkg::SEG_POST;
        end
      end else if (unit_end) begin
        pos_nxt = 3'd0;
        if (seg_eff == u8esc_pkg::SEG_MAIN) begin
          half_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= u8esc_pkg::SEG_PRE;
      pos_r  <= 3'd0;
      cnt_r  <= 2'd0;
      half_r <= 1'b0;
    end else begin
      seg_r  <= seg_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      half_r <= half_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= cur_char;
      out_last_r <= job_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign last_of_run = out_last_r;

  `U8ESC_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= 3'd5, "char position past end of escape")
  `U8ESC_ASSERT_NOW(a_idle_at_start, !head_valid,
    seg_r == u8esc_pkg::SEG_PRE && pos_r == 3'd0 && cnt_r == 2'd0 && !half_r,
    "sequencer not at job start while queue empty")
  `U8ESC_ASSERT_NEXT(a_pop_shows_last, pop, out_valid_r && out_last_r,
    "job retired without a last beat")

endmodule

### rtl/utf8_to_ascii_json_escaper.sv
// UTF-8 to ASCII JSON string escaper.
// A taken byte's job is queued; its first character is then loaded into the output register.
// Throughput: one input beat per cycle while the job queue has room; output is one
// character per cycle while out_tready is high; a byte giving N characters holds the back end.
// Reset (rst_n low, synchronous) empties the queue, drops any pending UTF-8 sequence
// and clears out_tvalid.
module utf8_to_ascii_json_escaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast   // last_of_run
);

  logic            push;
  u8esc_pkg::job_t push_job;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  u8esc_pkg::job_t head_job;
  logic [6:0]      out_char;

  u8esc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .end_of_text (in_tlast),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  u8esc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u8esc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_char    (out_char),
    .last_of_run (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule
